>>> sv/vhbs_pkg.sv
// Shared types, codes and constants for the voxel histogram box smoother.
package vhbs_pkg;

   // Item codes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_SMOOTH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] REG_DIM_X  = 2'd0;
   localparam logic [1:0] REG_DIM_Y  = 2'd1;
   localparam logic [1:0] REG_DIM_Z  = 2'd2;
   localparam logic [1:0] REG_RADIUS = 2'd3;

   // Defaults
   localparam int unsigned MAX_DIM_DEF    = 32;
   localparam int unsigned MAX_RADIUS_DEF = 3;
   localparam int unsigned CELL_BITS_DEF  = 16;

   // Fixed widths of the register and coordinate paths
   localparam int unsigned DIM_W   = 6;
   localparam int unsigned RAD_W   = 3;
   localparam int unsigned OFS_W   = RAD_W + 1;
   localparam int unsigned ROW_W   = 2 * DIM_W;
   localparam int unsigned MUL_W   = 3 * DIM_W;
   localparam int unsigned CSR_W   = 6;
   localparam int unsigned CUBE_W  = 12;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [7:0]  x_index;
      logic signed [7:0]  y_index;
      logic signed [7:0]  z_index;
      logic [15:0]        weight;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic        in_bounds;
      logic [31:0] inside_total;
      logic [31:0] grand_total;
      logic        total_overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_ARD,
      ST_AUPD,
      ST_NBR,
      ST_SRD,
      ST_SACC,
      ST_SDIV,
      ST_SWR,
      ST_CRD,
      ST_CWR,
      ST_DONE
   } state_type;

   // Box volume (2r+1)^3 for radius r
   function automatic logic [CUBE_W-1:0] box_volume(input logic [RAD_W-1:0] r);
      logic [CUBE_W-1:0] v;
      case (r)
         3'd0:    v = 12'd1;
         3'd1:    v = 12'd27;
         3'd2:    v = 12'd125;
         3'd3:    v = 12'd343;
         3'd4:    v = 12'd729;
         3'd5:    v = 12'd1331;
         3'd6:    v = 12'd2197;
         default: v = 12'd3375;
      endcase
      return v;
   endfunction

endpackage

>>> sv/voxel_histogram_box_smoother_top.sv
// Top level of the voxel histogram box smoother.
//
// Usage:
//   req channel (valid/ready) carries one item: op, signed x/y/z indices, weight.
//   rsp channel (valid/ready) returns exactly one item per request.
//   csr port writes dim_x, dim_y, dim_z and box_radius; write only while idle.
// Sequence:
//   add: address multiply x2, cell read, write. read: address multiply x2,
//   cell read; out-of-bounds add/read and unused op go straight to the result.
//   smooth: per cell, a walk over the (2r+1)^3 neighbors (select, two
//   address multiplies, read, accumulate) through the one cell-store read port,
//   then the restoring divider over the CELL_BITS+clog2((2*MAX_RADIUS+1)^3+1)-bit
//   sum and the buffer write; then a copy back (read, write) of every cell.
// Throughput: one item at a time; req_ready is high only in the idle state.
// Reset: synchronous; afterwards the cell store is cleared one entry a cycle,
//   all MAX_DIM^3 entries (32768 by default), with req_ready low meanwhile.
// Stall: a finished result sits in the output register; a new item can be
//   accepted and worked on, but its result waits until rsp is taken.
module voxel_histogram_box_smoother_top #(
   parameter int unsigned MAX_DIM    = vhbs_pkg::MAX_DIM_DEF,
   parameter int unsigned MAX_RADIUS = vhbs_pkg::MAX_RADIUS_DEF,
   parameter int unsigned CELL_BITS  = vhbs_pkg::CELL_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vhbs_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vhbs_pkg::rsp_type     rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [vhbs_pkg::CSR_W-1:0] csr_wdata
);
   import vhbs_pkg::*;

   localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned CNT_MAX = (2 * MAX_RADIUS + 1) ** 3;
   localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);
   localparam int unsigned ACC_W   = CELL_BITS + CNT_W;
   localparam int unsigned STEP_W  = $clog2(ACC_W + 1);

   // Configuration registers
   logic [DIM_W-1:0] dim_x_ff, dim_y_ff, dim_z_ff;
   logic [1:0]       radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff  <= DIM_W'(32);
         dim_y_ff  <= DIM_W'(32);
         dim_z_ff  <= DIM_W'(32);
         radius_ff <= 2'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DIM_X:  dim_x_ff  <= csr_wdata[DIM_W-1:0];
            REG_DIM_Y:  dim_y_ff  <= csr_wdata[DIM_W-1:0];
            REG_DIM_Z:  dim_z_ff  <= csr_wdata[DIM_W-1:0];
            REG_RADIUS: radius_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Effective dimensions and radius
   logic [DIM_W-1:0] dx, dy, dz;
   logic [RAD_W-1:0] r_eff;
   logic signed [OFS_W-1:0] r_pos, r_neg;

   assign dx = (32'(dim_x_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_x_ff;
   assign dy = (32'(dim_y_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_y_ff;
   assign dz = (32'(dim_z_ff) > MAX_DIM) ? DIM_W'(MAX_DIM) : dim_z_ff;
   assign r_eff = (32'(radius_ff) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_ff);
   assign r_pos = $signed({1'b0, r_eff});
   assign r_neg = -r_pos;

   // State and datapath registers
   state_type state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [15:0]           weight_ff, weight_in;
   logic                  hit_ff, hit_in;
   logic [DIM_W-1:0]      ax_ff, ay_ff, az_ff, ax_in, ay_in, az_in;
   logic [DIM_W-1:0]      cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic signed [OFS_W-1:0] ol_ff, om_ff, on_ff, ol_in, om_in, on_in;
   logic [ROW_W-1:0]      t_ff, t_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [ADDR_W-1:0]     c_ff, c_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [CNT_W:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [31:0]           inside_sum_ff, inside_sum_in, grand_sum_ff, grand_sum_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [CELL_BITS-1:0]  rdata_ff, buf_rd_ff;

   // Memories
   logic [CELL_BITS-1:0] cell_store [DEPTH];
   logic [CELL_BITS-1:0] smooth_buffer [DEPTH];
   logic                 st_we, buf_we;
   logic [ADDR_W-1:0]    st_waddr;
   logic [CELL_BITS-1:0] st_wdata;

   always_ff @(posedge clock) begin
      if (st_we) begin
         cell_store[st_waddr] <= st_wdata;
      end
      rdata_ff <= cell_store[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         smooth_buffer[c_ff] <= acc_ff[CELL_BITS-1:0];
      end
      buf_rd_ff <= smooth_buffer[c_ff];
   end

   // Request decode
   logic accept, req_inside, any_dim_zero;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_inside = !req_data.x_index[7] && (req_data.x_index[6:0] < {1'b0, dx})
                    && !req_data.y_index[7] && (req_data.y_index[6:0] < {1'b0, dy})
                    && !req_data.z_index[7] && (req_data.z_index[6:0] < {1'b0, dz});
   assign any_dim_zero = (dx == '0) || (dy == '0) || (dz == '0);

   // Shared address unit: t = y + dy*z, then addr = x + dx*t
   logic [ROW_W-1:0] mul1;
   logic [MUL_W-1:0] mul2;

   assign mul1 = ROW_W'(ay_ff) + ROW_W'(dy) * ROW_W'(az_ff);
   assign mul2 = MUL_W'(ax_ff) + MUL_W'(dx) * MUL_W'(t_ff);

   // Neighbor coordinates with edge fallback to the center
   logic signed [7:0] px, py, pz;
   logic              px_ok, py_ok, pz_ok;

   assign px = $signed({2'b00, cx_ff}) + 8'(ol_ff);
   assign py = $signed({2'b00, cy_ff}) + 8'(om_ff);
   assign pz = $signed({2'b00, cz_ff}) + 8'(on_ff);
   assign px_ok = !px[7] && (px[6:0] < {1'b0, dx});
   assign py_ok = !py[7] && (py[6:0] < {1'b0, dy});
   assign pz_ok = !pz[7] && (pz[6:0] < {1'b0, dz});

   // Loop end flags
   logic box_last, cell_last, clear_last, div_last;

   assign box_last   = (ol_ff == r_pos) && (om_ff == r_pos) && (on_ff == r_pos);
   assign cell_last  = (cx_ff == dx - 1'b1) && (cy_ff == dy - 1'b1) && (cz_ff == dz - 1'b1);
   assign clear_last = (c_ff == ADDR_W'(DEPTH - 1));
   assign div_last   = (step_ff == STEP_W'(ACC_W - 1));

   // Divider step
   logic [CNT_W:0] rem_sh;
   logic           rem_ge;

   assign rem_sh = {rem_ff[CNT_W-1:0], acc_ff[ACC_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, cnt_ff});

   // Grand total update
   logic [32:0] grand_add;

   assign grand_add = {1'b0, grand_sum_ff} + 33'(req_data.weight);

   logic rsp_load;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clear_last) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_SMOOTH) begin
                  state_in = any_dim_zero ? ST_DONE : ST_NBR;
               end else if ((req_data.op == OP_ADD || req_data.op == OP_READ) && req_inside) begin
                  state_in = ST_MUL1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = (op_ff == OP_SMOOTH) ? ST_SRD : ST_ARD;
         ST_ARD:  state_in = (op_ff == OP_ADD) ? ST_AUPD : ST_DONE;
         ST_AUPD: state_in = ST_DONE;
         ST_NBR:  state_in = ST_MUL1;
         ST_SRD:  state_in = ST_SACC;
         ST_SACC: state_in = box_last ? ST_SDIV : ST_NBR;
         ST_SDIV: if (div_last) state_in = ST_SWR;
         ST_SWR:  state_in = cell_last ? ST_CRD : ST_NBR;
         ST_CRD:  state_in = ST_CWR;
         ST_CWR:  state_in = cell_last ? ST_DONE : ST_CRD;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls
   always_comb begin
      op_in = op_ff;  weight_in = weight_ff;  hit_in = hit_ff;
      ax_in = ax_ff;  ay_in = ay_ff;  az_in = az_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;
      ol_in = ol_ff;  om_in = om_ff;  on_in = on_ff;
      t_in = t_ff;  addr_in = addr_ff;  c_in = c_ff;
      acc_in = acc_ff;  rem_in = rem_ff;  cnt_in = cnt_ff;  step_in = step_ff;
      inside_sum_in = inside_sum_ff;  grand_sum_in = grand_sum_ff;  ovf_in = ovf_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      st_we = 1'b0;  st_waddr = c_ff;  st_wdata = '0;
      buf_we = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            st_we = 1'b1;
            c_in  = c_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in     = req_data.op;
               weight_in = req_data.weight;
               hit_in    = req_inside && (req_data.op == OP_ADD || req_data.op == OP_READ);
               ax_in     = req_data.x_index[DIM_W-1:0];
               ay_in     = req_data.y_index[DIM_W-1:0];
               az_in     = req_data.z_index[DIM_W-1:0];
               cx_in = '0;  cy_in = '0;  cz_in = '0;
               ol_in = r_neg;  om_in = r_neg;  on_in = r_neg;
               c_in   = '0;
               acc_in = '0;
               cnt_in = CNT_W'(box_volume(r_eff));
               if (req_data.op == OP_ADD) begin
                  grand_sum_in = grand_add[31:0];
                  if (grand_add[32] || grand_add[31:0] == 32'hFFFF_FFFF) ovf_in = 1'b1;
                  if (req_inside) inside_sum_in = inside_sum_ff + 32'(req_data.weight);
               end
            end
         end
         ST_MUL1: t_in = mul1;
         ST_MUL2: addr_in = ADDR_W'(mul2);
         ST_ARD: ;
         ST_AUPD: begin
            st_we    = 1'b1;
            st_waddr = addr_ff;
            st_wdata = rdata_ff + CELL_BITS'(weight_ff);
         end
         ST_NBR: begin
            ax_in = px_ok ? px[DIM_W-1:0] : cx_ff;
            ay_in = py_ok ? py[DIM_W-1:0] : cy_ff;
            az_in = pz_ok ? pz[DIM_W-1:0] : cz_ff;
         end
         ST_SRD: ;
         ST_SACC: begin
            acc_in  = acc_ff + ACC_W'(rdata_ff);
            rem_in  = '0;
            step_in = '0;
            if (on_ff != r_pos) begin
               on_in = on_ff + 1'b1;
            end else begin
               on_in = r_neg;
               if (om_ff != r_pos) begin
                  om_in = om_ff + 1'b1;
               end else begin
                  om_in = r_neg;
                  ol_in = ol_ff + 1'b1;
               end
            end
         end
         ST_SDIV: begin
            rem_in  = rem_ge ? (rem_sh - {1'b0, cnt_ff}) : rem_sh;
            acc_in  = {acc_ff[ACC_W-2:0], rem_ge};
            step_in = step_ff + 1'b1;
         end
         ST_SWR, ST_CWR: begin
            if (state_ff == ST_SWR) begin
               buf_we = 1'b1;
            end else begin
               st_we    = 1'b1;
               st_wdata = buf_rd_ff;
            end
            acc_in = '0;
            ol_in = r_neg;  om_in = r_neg;  on_in = r_neg;
            c_in  = cell_last ? '0 : c_ff + 1'b1;
            if (cx_ff != dx - 1'b1) begin
               cx_in = cx_ff + 1'b1;
            end else begin
               cx_in = '0;
               if (cy_ff != dy - 1'b1) begin
                  cy_in = cy_ff + 1'b1;
               end else begin
                  cy_in = '0;
                  cz_in = (cz_ff != dz - 1'b1) ? cz_ff + 1'b1 : '0;
               end
            end
         end
         ST_CRD: ;
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_in.cell_value     = (op_ff == OP_READ && hit_ff) ? 16'(rdata_ff) : 16'd0;
               rsp_in.in_bounds      = hit_ff;
               rsp_in.inside_total   = inside_sum_ff;
               rsp_in.grand_total    = grand_sum_ff;
               rsp_in.total_overflow = ovf_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         c_ff          <= '0;
         inside_sum_ff <= '0;
         grand_sum_ff  <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         c_ff          <= c_in;
         inside_sum_ff <= inside_sum_in;
         grand_sum_ff  <= grand_sum_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;  weight_ff <= weight_in;  hit_ff <= hit_in;
      ax_ff <= ax_in;  ay_ff <= ay_in;  az_ff <= az_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;
      ol_ff <= ol_in;  om_ff <= om_in;  on_ff <= on_in;
      t_ff <= t_in;  addr_ff <= addr_in;
      acc_ff <= acc_in;  rem_ff <= rem_in;  cnt_ff <= cnt_in;  step_ff <= step_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/vhbs_checker.sv
// Port-level checker for the voxel histogram box smoother, bound to the top level.
module vhbs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input vhbs_pkg::rsp_type rsp_data
);
   import vhbs_pkg::*;

   // No result and no intake right after reset (store clearing)
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("result or ready right after reset");

   // A missed cell never reports a value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_bounds |-> rsp_data.cell_value == 16'd0)
      else $error("cell value without a hit");

   // Stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Overflow flag is sticky across stalls
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_overflow && !rsp_ready |=> rsp_data.total_overflow)
      else $error("overflow flag dropped");

endmodule

bind voxel_histogram_box_smoother_top vhbs_checker u_vhbs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb.sv
// Self-checking testbench for the voxel histogram box smoother top level.
module tb;
   import vhbs_pkg::*;

   localparam int QUIET_LIMIT = 500000;   // covers the reset clear and the slowest smooth
   localparam int SMOOTH_BUDGET = 25000;  // rough cycle budget for a random smooth

   // Mirror of the grid, the totals and the registers; holds the expected results
   class hist_board;
      logic [15:0] cells[32768];
      logic [15:0] smooth_tmp[32768];
      int unsigned dims[3];
      int unsigned radius;
      logic [31:0] inside_sum, grand_sum;
      bit          ovf_seen;
      rsp_type     pending[$];
      int          errors, checked, smooths;

      function new();
         foreach (cells[i]) cells[i] = '0;
         dims = '{32, 32, 32};
         radius = 1;
         inside_sum = '0;
         grand_sum = '0;
         ovf_seen = 0;
         errors = 0;
         checked = 0;
         smooths = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CSR_W-1:0] v);
         case (idx)
            REG_DIM_X:  dims[0] = v;
            REG_DIM_Y:  dims[1] = v;
            REG_DIM_Z:  dims[2] = v;
            REG_RADIUS: radius = v[1:0];
            default: ;
         endcase
      endfunction

      function int eff(int i);
         return (dims[i] > 32) ? 32 : dims[i];
      endfunction

      function int box_r();
         return (radius > 3) ? 3 : radius;
      endfunction

      // rough cycle cost of one smooth at the current setting
      function int smooth_cost();
         int s;
         s = 2 * box_r() + 1;
         return eff(0) * eff(1) * eff(2) * (s * s * s * 5 + 28);
      endfunction

      // box filter over a snapshot; out-of-range neighbors fold to the center
      function void smooth_grid();
         int dx, dy, dz, r, side, a;
         int px, py, pz;
         longint unsigned acc, cnt;
         dx = eff(0);
         dy = eff(1);
         dz = eff(2);
         r = box_r();
         side = 2 * r + 1;
         cnt = side * side * side;
         for (int z = 0; z < dz; z++)
            for (int y = 0; y < dy; y++)
               for (int x = 0; x < dx; x++) begin
                  acc = 0;
                  for (int l = -r; l <= r; l++)
                     for (int m = -r; m <= r; m++)
                        for (int n = -r; n <= r; n++) begin
                           px = x + l;
                           py = y + m;
                           pz = z + n;
                           if (px < 0 || px >= dx) px = x;
                           if (py < 0 || py >= dy) py = y;
                           if (pz < 0 || pz >= dz) pz = z;
                           acc += cells[px + dx * (py + dy * pz)];
                        end
                  smooth_tmp[x + dx * (y + dy * z)] = 16'(acc / cnt);
               end
         for (int z = 0; z < dz; z++)
            for (int y = 0; y < dy; y++)
               for (int x = 0; x < dx; x++) begin
                  a = x + dx * (y + dy * z);
                  cells[a] = smooth_tmp[a];
               end
      endfunction

      // work out the result of one accepted item
      function void note_item(req_type it);
         int x, y, z, dx, dy, dz, a;
         bit hit;
         logic [32:0] s;
         rsp_type e;
         x = $signed(it.x_index);
         y = $signed(it.y_index);
         z = $signed(it.z_index);
         dx = eff(0);
         dy = eff(1);
         dz = eff(2);
         hit = x >= 0 && x < dx && y >= 0 && y < dy && z >= 0 && z < dz;
         a = hit ? x + dx * (y + dy * z) : 0;
         e = '0;
         case (it.op)
            OP_ADD: begin
               if (hit) begin
                  cells[a] = cells[a] + it.weight;
                  inside_sum = inside_sum + it.weight;
                  e.in_bounds = 1'b1;
               end
               s = {1'b0, grand_sum} + it.weight;
               grand_sum = s[31:0];
               if (s[32] || grand_sum == 32'hFFFF_FFFF) ovf_seen = 1;
            end
            OP_SMOOTH: begin
               smooth_grid();
               smooths++;
            end
            OP_READ: begin
               if (hit) begin
                  e.cell_value = cells[a];
                  e.in_bounds = 1'b1;
               end
            end
            default: ;
         endcase
         e.inside_total = inside_sum;
         e.grand_total = grand_sum;
         e.total_overflow = ovf_seen;
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item %h", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.cell_value !== e.cell_value) begin
            $error("cell_value expected %0h actual %0h", e.cell_value, got.cell_value);
            errors++;
         end
         if (got.in_bounds !== e.in_bounds) begin
            $error("in_bounds expected %0b actual %0b", e.in_bounds, got.in_bounds);
            errors++;
         end
         if (got.inside_total !== e.inside_total) begin
            $error("inside_total expected %0h actual %0h", e.inside_total,
                   got.inside_total);
            errors++;
         end
         if (got.grand_total !== e.grand_total) begin
            $error("grand_total expected %0h actual %0h", e.grand_total, got.grand_total);
            errors++;
         end
         if (got.total_overflow !== e.total_overflow) begin
            $error("total_overflow expected %0b actual %0b", e.total_overflow,
                   got.total_overflow);
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   hist_board board;
   int send_idle, recv_idle, hold_req, hold_next;
   int items_sent, reg_writes;

   voxel_histogram_box_smoother_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // result side: check, then pick ready for the next cycle
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog on cycles without any accepted item
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // offer one item, with random gaps ahead of it; returns at the accepting edge
   task automatic send_item(req_type it);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      board.note_item(it);
      items_sent++;
   endtask

   task automatic send(logic [1:0] op, int x, int y, int z, int w);
      req_type it;
      it.op = op;
      it.x_index = 8'(x);
      it.y_index = 8'(y);
      it.z_index = 8'(z);
      it.weight = 16'(w);
      send_item(it);
   endtask

   // let every outstanding result come back and the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_regs(int dx, int dy, int dz, int r);
      logic [CSR_W-1:0] vals[4];
      vals = '{CSR_W'(dx), CSR_W'(dy), CSR_W'(dz), CSR_W'(r)};
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         board.set_reg(2'(i), vals[i]);
         reg_writes++;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_coord(int d);
      if (d == 0 || $urandom_range(3) == 0) return int'($urandom_range(255)) - 128;
      return $urandom_range(d - 1);
   endfunction

   function automatic req_type rand_item();
      req_type it;
      int k;
      bit cheap;
      cheap = board.smooth_cost() <= SMOOTH_BUDGET;
      k = $urandom_range(99);
      if (k < 52) it.op = OP_ADD;
      else if (k < 92) it.op = OP_READ;
      else if (k < 96 && cheap) it.op = OP_SMOOTH;
      else if (k < 96) it.op = OP_READ;
      else it.op = OP_NONE;
      it.x_index = 8'(pick_coord(board.eff(0)));
      it.y_index = 8'(pick_coord(board.eff(1)));
      it.z_index = 8'(pick_coord(board.eff(2)));
      case ($urandom_range(5))
         0: it.weight = 16'hFFFF;
         1: it.weight = 16'($urandom_range(15));
         default: it.weight = 16'($urandom);
      endcase
      return it;
   endfunction

   // several register settings, each followed by a burst of random items
   task automatic run_phase(int settings, int per_setting, bit pause_mid);
      int d[3];
      for (int s = 0; s < settings; s++) begin
         for (int i = 0; i < 3; i++)
            d[i] = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(1, 6);
         write_regs(d[0], d[1], d[2], $urandom_range(3));
         // start a pending receiver hold-off while items keep coming
         if (hold_next > 0) begin
            hold_req = hold_next;
            hold_next = 0;
         end
         for (int n = 0; n < per_setting; n++) begin
            send_item(rand_item());
            if (pause_mid && s == 1 && n == per_setting / 2) wait_idle();
         end
      end
   endtask

   initial begin
      board = new();
      send_idle = 0;
      recv_idle = 0;
      hold_req = 0;
      hold_next = 0;
      items_sent = 0;
      reg_writes = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = REG_DIM_X;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every op, bounds, wrap and box edges
      write_regs(4, 5, 6, 1);
      send(OP_ADD, 0, 0, 0, 16'hFFFF);
      send(OP_ADD, 0, 0, 0, 2);
      send(OP_ADD, 3, 4, 5, 16'h1234);
      send(OP_ADD, 4, 0, 0, 7);
      send(OP_ADD, -1, 0, 0, 9);
      send(OP_ADD, 0, -128, 0, 16'h8000);
      send(OP_ADD, 127, 127, 127, 16'hFFFF);
      send(OP_ADD, 0, 0, 6, 0);
      send(OP_READ, 0, 0, 0, 0);
      send(OP_READ, 3, 4, 5, 16'hFFFF);
      send(OP_READ, -128, -128, -128, 0);
      send(OP_READ, 0, 5, 0, 0);
      send(OP_NONE, -1, -1, -1, 16'hFFFF);
      send(OP_SMOOTH, 0, 0, 0, 0);
      send(OP_READ, 0, 0, 0, 0);
      send(OP_READ, 3, 4, 5, 0);
      write_regs(4, 4, 4, 3);
      send(OP_ADD, 1, 1, 1, 16'h7FFF);
      send(OP_SMOOTH, 0, 0, 0, 0);
      send(OP_READ, 1, 1, 1, 0);
      write_regs(63, 0, 32, 0);
      send(OP_ADD, 31, 0, 31, 5);
      send(OP_SMOOTH, 0, 0, 0, 0);
      write_regs(32, 32, 32, 0);
      send(OP_ADD, 31, 31, 31, 16'h5555);
      send(OP_READ, 31, 31, 31, 0);
      send(OP_READ, 32, 31, 31, 0);

      // random phases; receiver holds off early to back the block up
      send_idle = 10;
      recv_idle = 88;
      hold_next = 3000;
      run_phase(4, 40, 1'b0);
      send_idle = 88;
      recv_idle = 10;
      run_phase(4, 40, 1'b1);
      send_idle = 0;
      recv_idle = 0;
      run_phase(4, 40, 1'b0);

      wait_idle();
      $display("sent %0d items, checked %0d results, %0d smooths, %0d register writes",
               items_sent, board.checked, board.smooths, reg_writes);
      $display("idle mixes on both sides, a long receiver hold-off and box edge cases");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
